FILE: src/lsm_pkg.sv
// Shared command codes, result kinds and checksum helper for the LIN frame engine.
package lsm_pkg;

    localparam logic [3:0] CMD_RX_BYTE     = 4'd0;
    localparam logic [3:0] CMD_TICK        = 4'd1;
    localparam logic [3:0] CMD_LOAD_SLOT   = 4'd2;
    localparam logic [3:0] CMD_ENABLE      = 4'd3;
    localparam logic [3:0] CMD_DISABLE     = 4'd4;
    localparam logic [3:0] CMD_DISABLE_ALL = 4'd5;
    localparam logic [3:0] CMD_ERASE_ALL   = 4'd6;
    localparam logic [3:0] CMD_SLOT_DATA   = 4'd7;
    localparam logic [3:0] CMD_MASTER_BYTE = 4'd8;
    localparam logic [3:0] CMD_MASTER_HDR  = 4'd9;
    localparam logic [3:0] CMD_MASTER_FRM  = 4'd10;

    localparam logic [1:0] KIND_BREAK = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;
    localparam logic [1:0] KIND_DATA  = 2'd3;

    localparam logic [1:0] ACT_MONITOR = 2'd1;
    localparam logic [1:0] ACT_SLAVE   = 2'd2;

    localparam logic [7:0] LIN_SYNC  = 8'h55;
    localparam logic [7:0] PID_MASK  = 8'h3F;
    localparam logic [7:0] TIMEOUT_RESET = 8'd3;

    typedef logic [7:0] t_byte;

    // one step of the end-around-carry sum
    function automatic t_byte lin_add(input t_byte s, input t_byte d);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, d};
        if (t > 9'd255) begin
            t = t - 9'd255;
        end
        return t[7:0];
    endfunction

endpackage

FILE: src/lin_slave_monitor_frame_engine.sv
// LIN slave/monitor frame engine top level: command sequencer, slot table, frame buffers.
//
// One word is taken per command; the engine then stays busy until its work is done.
// Simple commands pass through an execute state and back to idle. A PID search walks
// the slot table one slot per cycle. Result words go out one per cycle while the output
// is free; each slave response byte passes through a read state and then an emit state,
// because every read of the data memory is registered before its data is available. A
// frame check scans the receive buffer one byte per cycle. Erase all, and the period
// after reset, run a clearing pass over the whole data memory during which no command
// is taken.
module lin_slave_monitor_frame_engine #(
    parameter int SLOT_COUNT     = 16,
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_break_seen,
    input  logic [3:0]  i_slot_index,
    input  logic        i_slot_active,
    input  logic [1:0]  i_slot_action,
    input  logic [7:0]  i_slot_pid,
    input  logic [3:0]  i_slot_len,
    input  logic [2:0]  i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_frame_pid,
    input  logic [3:0]  i_frame_len,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_value,
    output logic [3:0]  o_frame_length,
    output logic        o_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import lsm_pkg::*;

    localparam int SW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BW     = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
    localparam int RX_CAP = MAX_DATA_BYTES + 1;
    localparam int RW     = $clog2(RX_CAP);
    localparam int DEPTH  = SLOT_COUNT * MAX_DATA_BYTES;
    localparam int DAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_EXEC, S_SRCH, S_SRD, S_SEM, S_SCK,
        S_FSUM, S_FHEAD, S_FDAT, S_MST
    } t_state;

    typedef enum logic [2:0] {P_IDLE, P_PID, P_MPID, P_DATA} t_phase;

    t_state      r_state;
    t_phase      r_phase;
    logic [3:0]  r_cmd;
    logic [7:0]  r_rxb;
    logic        r_brk;
    logic [3:0]  r_si;
    logic        r_sact;
    logic [1:0]  r_sacn;
    logic [7:0]  r_spid;
    logic [3:0]  r_slen;
    logic [2:0]  r_bi;
    logic [7:0]  r_bv;
    logic [7:0]  r_fpid;
    logic [3:0]  r_flen;

    logic        r_act  [SLOT_COUNT];
    logic [1:0]  r_acn  [SLOT_COUNT];
    logic [7:0]  r_pid  [SLOT_COUNT];
    logic [3:0]  r_len  [SLOT_COUNT];
    logic [7:0]  r_mbuf [MAX_DATA_BYTES];
    logic [7:0]  r_rbuf [RX_CAP];

    logic [7:0]  r_timeout;
    logic [7:0]  r_tick;
    logic [3:0]  r_cnt;
    logic [7:0]  r_cur;
    logic [SW:0] r_idx;
    logic [3:0]  r_j;
    logic [3:0]  r_n;
    logic [7:0]  r_sum;
    logic [DAW-1:0] r_clr;

    logic        r_ovalid;
    logic [1:0]  r_kind;
    logic [7:0]  r_value;
    logic [3:0]  r_olen;
    logic        r_last;

    logic           o_free;
    logic           slot_ok;
    logic           byte_ok;
    logic [6:0]     si_ext;
    logic [SW-1:0]  si_w;
    logic [SW-1:0]  idx_w;
    logic [BW-1:0]  bi_w;
    logic [3:0]     slen_cap;
    logic [3:0]     flen_cap;
    logic [3:0]     hit_len;
    logic [3:0]     mj;
    logic           ram_we;
    logic [DAW-1:0] ram_waddr;
    logic [7:0]     ram_wdata;
    logic [DAW-1:0] ram_raddr;
    logic [7:0]     ram_rdata;
    logic [7:0]     m_val;
    logic [1:0]     m_kind;
    logic           m_last;
    logic           m_is_data;

    always_comb begin
        o_free    = !r_ovalid || !i_stall;
        si_ext    = {3'b000, r_si};
        si_w      = si_ext[SW-1:0];
        idx_w     = r_idx[SW-1:0];
        bi_w      = r_bi[BW-1:0];
        slot_ok   = si_ext < 7'(SLOT_COUNT);
        byte_ok   = {1'b0, r_bi} < 4'(MAX_DATA_BYTES);
        flen_cap  = (r_flen > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : r_flen;
        hit_len   = (r_len[idx_w] > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : r_len[idx_w];
        slen_cap  = hit_len;
        mj        = r_j - 4'd3;

        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = 8'd0;
        if (r_state == S_CLR) begin
            ram_we = 1'b1;
        end else if (r_state == S_EXEC && r_cmd == CMD_SLOT_DATA && slot_ok && byte_ok) begin
            ram_we    = 1'b1;
            ram_waddr = DAW'(si_w) * DAW'(MAX_DATA_BYTES) + DAW'(r_bi);
            ram_wdata = r_bv;
        end
        ram_raddr = DAW'(idx_w) * DAW'(MAX_DATA_BYTES) + DAW'(r_j);

        // master transmit sequence: break, sync, pid, then data and checksum for a full frame only
        m_is_data = 1'b0;
        m_kind    = KIND_SEND;
        m_val     = ~r_sum;
        if (r_j == 4'd0) begin
            m_kind = KIND_BREAK;
            m_val  = 8'd0;
        end else if (r_j == 4'd1) begin
            m_val = LIN_SYNC;
        end else if (r_j == 4'd2) begin
            m_val = r_fpid;
        end else if (mj < r_n) begin
            m_is_data = 1'b1;
            m_val     = r_mbuf[mj[BW-1:0]];
        end
        if (r_cmd == CMD_MASTER_HDR) begin
            m_last = (r_j == 4'd2);
        end else begin
            m_last = (r_j == r_n + 4'd3);
        end
    end

    lsm_data_ram #(.DEPTH(DEPTH), .AW(DAW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_phase   <= P_IDLE;
            r_timeout <= TIMEOUT_RESET;
            r_tick    <= 8'd0;
            r_cnt     <= 4'd0;
            r_cur     <= 8'd0;
            r_idx     <= '0;
            r_j       <= 4'd0;
            r_n       <= 4'd0;
            r_sum     <= 8'd0;
            r_clr     <= '0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_act[i] <= 1'b0;
                r_acn[i] <= 2'd0;
                r_pid[i] <= 8'd0;
                r_len[i] <= 4'd0;
            end
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                r_mbuf[i] <= 8'd0;
            end
        end else begin
            if (i_psel && i_penable && i_pwrite && !i_paddr[2]) begin
                r_timeout <= i_pwdata[7:0];
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    if (r_clr == DAW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_command;
                        r_rxb   <= i_rx_byte;
                        r_brk   <= i_break_seen;
                        r_si    <= i_slot_index;
                        r_sact  <= i_slot_active;
                        r_sacn  <= i_slot_action;
                        r_spid  <= i_slot_pid;
                        r_slen  <= i_slot_len;
                        r_bi    <= i_byte_index;
                        r_bv    <= i_byte_value;
                        r_fpid  <= i_frame_pid;
                        r_flen  <= i_frame_len;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    case (r_cmd)
                        CMD_RX_BYTE: begin
                            case (r_phase)
                                P_IDLE: begin
                                    r_cnt <= 4'd0;
                                    if (r_brk && r_rxb == LIN_SYNC) begin
                                        r_tick  <= 8'd0;
                                        r_phase <= P_PID;
                                    end
                                end
                                P_PID: begin
                                    r_tick  <= 8'd0;
                                    r_cur   <= r_rxb;
                                    r_idx   <= '0;
                                    r_state <= S_SRCH;
                                end
                                P_MPID: begin
                                    r_cur   <= r_rxb;
                                    r_cnt   <= 4'd0;
                                    r_phase <= P_DATA;
                                end
                                P_DATA: begin
                                    r_tick <= 8'd0;
                                    r_rbuf[r_cnt[RW-1:0]] <= r_rxb;
                                    r_cnt <= r_cnt + 4'd1;
                                    if (r_cnt + 4'd1 == 4'(RX_CAP)) begin
                                        r_n     <= 4'(RX_CAP);
                                        r_j     <= 4'd0;
                                        r_sum   <= r_cur;
                                        r_state <= S_FSUM;
                                    end
                                end
                                default: begin
                                    r_phase <= P_IDLE;
                                    r_cnt   <= 4'd0;
                                    r_tick  <= 8'd0;
                                end
                            endcase
                        end
                        CMD_TICK: begin
                            if (r_phase != P_IDLE) begin
                                if (r_tick >= r_timeout) begin
                                    if (r_phase == P_DATA) begin
                                        r_n     <= r_cnt;
                                        r_j     <= 4'd0;
                                        r_sum   <= r_cur;
                                        r_state <= S_FSUM;
                                    end else begin
                                        r_phase <= P_IDLE;
                                        r_cnt   <= 4'd0;
                                        r_tick  <= 8'd0;
                                    end
                                end else begin
                                    r_tick <= r_tick + 8'd1;
                                end
                            end
                        end
                        CMD_LOAD_SLOT: begin
                            if (slot_ok) begin
                                r_act[si_w] <= r_sact;
                                r_acn[si_w] <= r_sacn;
                                r_pid[si_w] <= r_spid;
                                r_len[si_w] <= r_slen;
                            end
                        end
                        CMD_ENABLE: begin
                            if (slot_ok) begin
                                r_act[si_w] <= 1'b1;
                            end
                        end
                        CMD_DISABLE: begin
                            if (slot_ok) begin
                                r_act[si_w] <= 1'b0;
                            end
                        end
                        CMD_DISABLE_ALL: begin
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                r_act[i] <= 1'b0;
                            end
                        end
                        CMD_ERASE_ALL: begin
                            for (int i = 0; i < SLOT_COUNT; i++) begin
                                r_act[i] <= 1'b0;
                                r_pid[i] <= 8'd0;
                                r_len[i] <= 4'd0;
                            end
                            r_clr   <= '0;
                            r_state <= S_CLR;
                        end
                        CMD_MASTER_BYTE: begin
                            if (byte_ok) begin
                                r_mbuf[bi_w] <= r_bv;
                            end
                        end
                        CMD_MASTER_HDR, CMD_MASTER_FRM: begin
                            r_j     <= 4'd0;
                            r_n     <= flen_cap;
                            r_sum   <= r_fpid;
                            r_state <= S_MST;
                        end
                        default: begin
                        end
                    endcase
                end
                S_SRCH: begin
                    if (r_idx == (SW+1)'(SLOT_COUNT)) begin
                        r_phase <= P_IDLE;
                        r_cnt   <= 4'd0;
                        r_tick  <= 8'd0;
                        r_state <= S_IDLE;
                    end else if (r_act[idx_w] && r_pid[idx_w] == (r_cur & PID_MASK)) begin
                        if (r_acn[idx_w] == ACT_MONITOR) begin
                            r_phase <= P_DATA;
                            r_cnt   <= 4'd0;
                            r_state <= S_IDLE;
                        end else if (r_acn[idx_w] == ACT_SLAVE) begin
                            r_n     <= slen_cap;
                            r_j     <= 4'd0;
                            r_sum   <= r_cur;
                            r_state <= (slen_cap == 4'd0) ? S_SCK : S_SRD;
                        end else begin
                            r_phase <= P_IDLE;
                            r_cnt   <= 4'd0;
                            r_tick  <= 8'd0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SRD: begin
                    r_state <= S_SEM;
                end
                S_SEM: begin
                    if (o_free) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= KIND_SEND;
                        r_value  <= ram_rdata;
                        r_olen   <= 4'd0;
                        r_last   <= 1'b0;
                        r_sum    <= lin_add(r_sum, ram_rdata);
                        r_j      <= r_j + 4'd1;
                        r_state  <= (r_j + 4'd1 < r_n) ? S_SRD : S_SCK;
                    end
                end
                S_SCK: begin
                    if (o_free) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= KIND_SEND;
                        r_value  <= ~r_sum;
                        r_olen   <= 4'd0;
                        r_last   <= 1'b1;
                        r_phase  <= P_IDLE;
                        r_cnt    <= 4'd0;
                        r_tick   <= 8'd0;
                        r_state  <= S_IDLE;
                    end
                end
                S_FSUM: begin
                    if (r_n == 4'd0) begin
                        r_phase <= P_IDLE;
                        r_cnt   <= 4'd0;
                        r_tick  <= 8'd0;
                        r_state <= S_IDLE;
                    end else if (r_j < r_n - 4'd1) begin
                        r_sum <= lin_add(r_sum, r_rbuf[r_j[RW-1:0]]);
                        r_j   <= r_j + 4'd1;
                    end else if (r_rbuf[r_j[RW-1:0]] == ~r_sum) begin
                        r_state <= S_FHEAD;
                    end else begin
                        r_phase <= P_IDLE;
                        r_cnt   <= 4'd0;
                        r_tick  <= 8'd0;
                        r_state <= S_IDLE;
                    end
                end
                S_FHEAD: begin
                    if (o_free) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= KIND_FRAME;
                        r_value  <= r_cur & PID_MASK;
                        r_olen   <= r_n - 4'd1;
                        r_last   <= (r_n == 4'd1);
                        r_j      <= 4'd0;
                        if (r_n == 4'd1) begin
                            r_phase <= P_IDLE;
                            r_cnt   <= 4'd0;
                            r_tick  <= 8'd0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_FDAT;
                        end
                    end
                end
                S_FDAT: begin
                    if (o_free) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= KIND_DATA;
                        r_value  <= r_rbuf[r_j[RW-1:0]];
                        r_olen   <= 4'd0;
                        r_last   <= (r_j == r_n - 4'd2);
                        r_j      <= r_j + 4'd1;
                        if (r_j == r_n - 4'd2) begin
                            r_phase <= P_IDLE;
                            r_cnt   <= 4'd0;
                            r_tick  <= 8'd0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MST: begin
                    if (o_free) begin
                        r_ovalid <= 1'b1;
                        r_kind   <= m_kind;
                        r_value  <= m_val;
                        r_olen   <= 4'd0;
                        r_last   <= m_last;
                        r_j      <= r_j + 4'd1;
                        if (m_is_data) begin
                            r_sum <= lin_add(r_sum, m_val);
                        end
                        if (m_last) begin
                            r_cur   <= r_fpid;
                            r_cnt   <= 4'd0;
                            r_tick  <= 8'd0;
                            r_phase <= (r_cmd == CMD_MASTER_HDR) ? P_MPID : P_IDLE;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_kind         = r_kind;
    assign o_value        = r_value;
    assign o_frame_length = r_olen;
    assign o_last         = r_last;
    assign o_pready       = 1'b1;
    assign o_prdata       = i_paddr[2] ? 32'd0 : {24'd0, r_timeout};

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(RX_CAP))
        else $error("receive count beyond capacity");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_idx <= (SW+1)'(SLOT_COUNT)))
        else $error("slot search index out of range");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_value) && $stable(r_kind)))
        else $error("pending word overwritten");

    a_clr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> o_stall)
        else $error("command taken during clearing pass");
endmodule

FILE: src/lsm_data_ram.sv
// Slot response data memory: one write port, one registered read port.
module lsm_data_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: bench/tb.sv
// Self-checking bench for the LIN slave/monitor frame engine: directed and random command words.
module tb;
    import lsm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PID, S_MPID, S_DATA} t_eng_state;

    typedef struct packed {
        logic [3:0] cmd;
        logic [7:0] rx_byte;
        logic       brk;
        logic [3:0] slot_index;
        logic       slot_active;
        logic [1:0] slot_action;
        logic [7:0] slot_pid;
        logic [3:0] slot_len;
        logic [2:0] byte_index;
        logic [7:0] byte_value;
        logic [7:0] frame_pid;
        logic [3:0] frame_len;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [3:0] flen;
        logic       last;
    } t_lin_result;

    typedef logic [7:0] t_byte_arr [0:8];

    logic        clk;
    logic        rst_n;
    t_cmd_word   drv;
    logic        in_valid;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  out_kind;
    logic [7:0]  out_value;
    logic [3:0]  out_flen;
    logic        out_last;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_lin_result lin_expect_q[$];
    int          mismatches;
    int          words_sent;
    int          results_seen;
    int          hold_req;
    int          hold_cnt;
    int          stall_mode;
    int          mode_left;
    int          burst_left;

    // predictor state
    logic [7:0]  p_tmo;
    t_eng_state  p_state;
    logic        p_act [16];
    logic [1:0]  p_acn [16];
    logic [7:0]  p_pid [16];
    logic [3:0]  p_len [16];
    logic [7:0]  p_sdata [128];
    logic [7:0]  p_rxbuf [0:8];
    logic [3:0]  p_rxcnt;
    logic [7:0]  p_cur_pid;
    logic [7:0]  p_mbuf [0:7];
    logic [7:0]  p_ticks;

    lin_slave_monitor_frame_engine u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(out_stall),
        .i_command(drv.cmd), .i_rx_byte(drv.rx_byte), .i_break_seen(drv.brk),
        .i_slot_index(drv.slot_index), .i_slot_active(drv.slot_active),
        .i_slot_action(drv.slot_action), .i_slot_pid(drv.slot_pid),
        .i_slot_len(drv.slot_len), .i_byte_index(drv.byte_index),
        .i_byte_value(drv.byte_value), .i_frame_pid(drv.frame_pid),
        .i_frame_len(drv.frame_len),
        .o_valid(out_valid), .i_stall(in_stall),
        .o_kind(out_kind), .o_value(out_value), .o_frame_length(out_flen),
        .o_last(out_last),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] enh_checksum(input logic [7:0] pid, input t_byte_arr d,
                                                input int n);
        int s;
        s = pid;
        for (int i = 0; i < n; i++) begin
            s = s + d[i];
            if (s > 255) s = s - 255;
        end
        return 8'hFF - s[7:0];
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] value,
                                 input logic [3:0] flen);
        lin_expect_q.push_back('{kind, value, flen, 1'b0});
    endfunction

    function automatic void eng_idle();
        p_state = S_IDLE;
        p_rxcnt = 4'd0;
        p_ticks = 8'd0;
    endfunction

    function automatic void close_frame();
        int n;
        t_byte_arr d;
        n = p_rxcnt;
        for (int i = 0; i < 9; i++) d[i] = p_rxbuf[i];
        if (n > 0) begin
            if (d[n-1] == enh_checksum(p_cur_pid, d, n - 1)) begin
                emit(KIND_FRAME, p_cur_pid & PID_MASK, 4'(n - 1));
                for (int i = 0; i < n - 1; i++) emit(KIND_DATA, d[i], 4'd0);
            end
        end
        eng_idle();
    endfunction

    function automatic void line_byte(input logic [7:0] b, input logic brk);
        int m;
        int len;
        t_byte_arr d;
        case (p_state)
            S_IDLE: begin
                p_rxcnt = 4'd0;
                if (brk && b == LIN_SYNC) begin
                    p_ticks = 8'd0;
                    p_state = S_PID;
                end
            end
            S_PID: begin
                p_ticks = 8'd0;
                p_cur_pid = b;
                m = 16;
                for (int i = 15; i >= 0; i--)
                    if (p_act[i] && p_pid[i] == (b & PID_MASK)) m = i;
                if (m == 16) begin
                    eng_idle();
                end else if (p_acn[m] == ACT_MONITOR) begin
                    p_state = S_DATA;
                    p_rxcnt = 4'd0;
                end else if (p_acn[m] == ACT_SLAVE) begin
                    len = (p_len[m] > 8) ? 8 : p_len[m];
                    for (int j = 0; j < 9; j++) d[j] = (j < 8) ? p_sdata[m*8+j] : 8'd0;
                    for (int j = 0; j < len; j++) emit(KIND_SEND, d[j], 4'd0);
                    emit(KIND_SEND, enh_checksum(b, d, len), 4'd0);
                    eng_idle();
                end else begin
                    eng_idle();
                end
            end
            S_MPID: begin
                p_cur_pid = b;
                p_rxcnt = 4'd0;
                p_state = S_DATA;
            end
            default: begin
                p_ticks = 8'd0;
                if (p_rxcnt < 9) begin
                    p_rxbuf[p_rxcnt] = b;
                    p_rxcnt++;
                end
                if (p_rxcnt >= 9) close_frame();
            end
        endcase
    endfunction

    function automatic void predict_word(input t_cmd_word w);
        int base;
        int flen;
        t_byte_arr d;
        base = lin_expect_q.size();
        case (w.cmd)
            CMD_RX_BYTE: line_byte(w.rx_byte, w.brk);
            CMD_TICK: begin
                if (p_state != S_IDLE) begin
                    if (p_ticks >= p_tmo) begin
                        if (p_state == S_DATA) close_frame();
                        else eng_idle();
                    end else begin
                        p_ticks++;
                    end
                end
            end
            CMD_LOAD_SLOT: begin
                p_act[w.slot_index] = w.slot_active;
                p_acn[w.slot_index] = w.slot_action;
                p_pid[w.slot_index] = w.slot_pid;
                p_len[w.slot_index] = w.slot_len;
            end
            CMD_ENABLE: p_act[w.slot_index] = 1'b1;
            CMD_DISABLE: p_act[w.slot_index] = 1'b0;
            CMD_DISABLE_ALL: for (int i = 0; i < 16; i++) p_act[i] = 1'b0;
            CMD_ERASE_ALL: begin
                for (int i = 0; i < 16; i++) begin
                    p_act[i] = 1'b0;
                    p_pid[i] = 8'd0;
                    p_len[i] = 4'd0;
                end
                for (int i = 0; i < 128; i++) p_sdata[i] = 8'd0;
            end
            CMD_SLOT_DATA: p_sdata[w.slot_index*8 + w.byte_index] = w.byte_value;
            CMD_MASTER_BYTE: p_mbuf[w.byte_index] = w.byte_value;
            CMD_MASTER_HDR: begin
                emit(KIND_BREAK, 8'd0, 4'd0);
                emit(KIND_SEND, LIN_SYNC, 4'd0);
                emit(KIND_SEND, w.frame_pid, 4'd0);
                p_cur_pid = w.frame_pid;
                p_rxcnt = 4'd0;
                p_ticks = 8'd0;
                p_state = S_MPID;
            end
            CMD_MASTER_FRM: begin
                flen = (w.frame_len > 8) ? 8 : w.frame_len;
                for (int j = 0; j < 9; j++) d[j] = (j < 8) ? p_mbuf[j] : 8'd0;
                emit(KIND_BREAK, 8'd0, 4'd0);
                emit(KIND_SEND, LIN_SYNC, 4'd0);
                emit(KIND_SEND, w.frame_pid, 4'd0);
                for (int j = 0; j < flen; j++) emit(KIND_SEND, d[j], 4'd0);
                emit(KIND_SEND, enh_checksum(w.frame_pid, d, flen), 4'd0);
                p_cur_pid = w.frame_pid;
                eng_idle();
            end
            default: ;
        endcase
        if (lin_expect_q.size() > base) lin_expect_q[$].last = 1'b1;
    endfunction

    // receiver: stall pattern plus long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            in_stall <= 1'b0;
        end else begin
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                in_stall <= 1'b1;
            end else begin
                in_stall <= (stall_mode != 0) && ($urandom_range(0, 3) < stall_mode);
            end
        end
    end

    // result checker: accepted at the coming edge
    always @(negedge clk) begin
        t_lin_result got, want;
        if (rst_n && out_valid && !in_stall) begin
            got = '{out_kind, out_value, out_flen, out_last};
            results_seen++;
            if (lin_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d value=%h len=%0d last=%0d",
                             got.kind, got.value, got.flen, got.last);
            end else begin
                want = lin_expect_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp kind=%0d value=%h len=%0d last=%0d",
                                 want.kind, want.value, want.flen, want.last,
                                 " got kind=%0d value=%h len=%0d last=%0d",
                                 got.kind, got.value, got.flen, got.last);
                end
            end
        end
    end

    // called at a rising edge; returns at a rising edge
    task automatic send_word(input t_cmd_word w);
        int gap;
        drv <= w;
        in_valid <= 1'b1;
        forever begin
            @(negedge clk);
            if (!out_stall) break;
        end
        @(posedge clk);
        predict_word(w);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic t_cmd_word noise_word();
        t_cmd_word w;
        w = t_cmd_word'({$urandom, $urandom});
        return w;
    endfunction

    task automatic rx_b(input logic [7:0] b, input logic brk);
        t_cmd_word w;
        w = noise_word();
        w.cmd = CMD_RX_BYTE;
        w.rx_byte = b;
        w.brk = brk;
        send_word(w);
    endtask

    task automatic op(input logic [3:0] cmd, input logic [3:0] si);
        t_cmd_word w;
        w = noise_word();
        w.cmd = cmd;
        w.slot_index = si;
        send_word(w);
    endtask

    task automatic load_slot(input logic [3:0] si, input logic act, input logic [1:0] acn,
                             input logic [7:0] pid, input logic [3:0] len);
        t_cmd_word w;
        w = noise_word();
        w.cmd = CMD_LOAD_SLOT;
        w.slot_index = si;
        w.slot_active = act;
        w.slot_action = acn;
        w.slot_pid = pid;
        w.slot_len = len;
        send_word(w);
    endtask

    task automatic load_byte(input logic [3:0] cmd, input logic [3:0] si,
                             input logic [2:0] bi, input logic [7:0] bv);
        t_cmd_word w;
        w = noise_word();
        w.cmd = cmd;
        w.slot_index = si;
        w.byte_index = bi;
        w.byte_value = bv;
        send_word(w);
    endtask

    task automatic master(input logic [3:0] cmd, input logic [7:0] pid, input logic [3:0] len);
        t_cmd_word w;
        w = noise_word();
        w.cmd = cmd;
        w.frame_pid = pid;
        w.frame_len = len;
        send_word(w);
    endtask

    // response bytes after a header; good checksum unless corrupted, ticks out if short
    task automatic rx_response(input logic [7:0] pid, input int n, input logic good);
        t_byte_arr d;
        logic [7:0] cs;
        for (int i = 0; i < 9; i++) d[i] = 8'($urandom);
        cs = enh_checksum(pid, d, n);
        for (int i = 0; i < n; i++) rx_b(d[i], 1'($urandom_range(0, 1)));
        rx_b(good ? cs : cs ^ 8'h01, 1'b0);
        if (n < 8) repeat (int'(p_tmo) + 1) op(CMD_TICK, 4'd0);
    endtask

    task automatic header(input logic [7:0] pid);
        rx_b(LIN_SYNC, 1'b1);
        rx_b(pid, 1'b0);
    endtask

    task automatic drain(input int extra);
        in_valid <= 1'b0;
        while (lin_expect_q.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        p_tmo = data[7:0];
    endtask

    task automatic set_timeout(input logic [7:0] t);
        drain(200);
        apb_write(3'd0, {24'd0, t});
    endtask

    task automatic test_monitor_and_slave();
        load_slot(4'd0, 1'b1, ACT_MONITOR, 8'h10, 4'd8);
        load_slot(4'd1, 1'b1, ACT_SLAVE, 8'h21, 4'd15);
        load_slot(4'd2, 1'b1, 2'd0, 8'h30, 4'd2);
        load_slot(4'd3, 1'b1, 2'd3, 8'h31, 4'd2);
        load_slot(4'd4, 1'b0, ACT_MONITOR, 8'h11, 4'd2);
        load_slot(4'd15, 1'b1, ACT_SLAVE, 8'h10, 4'd0);
        for (int i = 0; i < 8; i++)
            load_byte(CMD_SLOT_DATA, 4'd1, 3'(i), (i == 0) ? 8'hFF : 8'($urandom));
        header(8'hD0);
        rx_response(8'hD0, 8, 1'b1);
        header(8'h10);
        rx_response(8'h10, 2, 1'b0);
        header(8'h10);
        repeat (int'(p_tmo) + 1) op(CMD_TICK, 4'd0);
        header(8'h10);
        rx_b(8'h55, 1'b1);
        rx_b(8'hAA, 1'b0);
        repeat (int'(p_tmo) + 1) op(CMD_TICK, 4'd0);
        header(8'h61);
        header(8'h30);
        header(8'h31);
        header(8'h11);
        header(8'h3F);
        rx_b(8'h55, 1'b0);
        rx_b(8'h00, 1'b1);
        repeat (int'(p_tmo) + 1) op(CMD_TICK, 4'd0);
    endtask

    task automatic test_master_commands();
        for (int i = 0; i < 8; i++) load_byte(CMD_MASTER_BYTE, 4'($urandom), 3'(i), 8'($urandom));
        master(CMD_MASTER_FRM, 8'hFF, 4'd8);
        master(CMD_MASTER_FRM, 8'h00, 4'd15);
        master(CMD_MASTER_FRM, 8'h42, 4'd0);
        master(CMD_MASTER_HDR, 8'h97, 4'd0);
        rx_b(8'h97, 1'b0);
        rx_response(8'h97, 3, 1'b1);
        header(8'h10);
        rx_b(8'h01, 1'b0);
        master(CMD_MASTER_HDR, 8'h05, 4'd0);
        repeat (int'(p_tmo) + 1) op(CMD_TICK, 4'd0);
    endtask

    task automatic test_table_edits();
        for (int c = 11; c < 16; c++) op(4'(c), 4'($urandom));
        op(CMD_DISABLE, 4'd15);
        op(CMD_DISABLE, 4'd0);
        header(8'h10);
        op(CMD_ENABLE, 4'd4);
        header(8'h11);
        rx_response(8'h11, 1, 1'b1);
        op(CMD_DISABLE_ALL, 4'd0);
        header(8'h21);
        op(CMD_ENABLE, 4'd1);
        header(8'h21);
        op(CMD_ERASE_ALL, 4'd0);
        op(CMD_ENABLE, 4'd1);
        header(8'h00);
    endtask

    task automatic random_traffic(input int target);
        int sel;
        int si;
        logic [7:0] pid;
        while (words_sent < target) begin
            sel = $urandom_range(0, 19);
            si = $urandom_range(0, 15);
            pid = {2'($urandom), p_pid[si][5:0]};
            if (sel < 7) begin
                header(pid);
                if (p_act[si] && p_acn[si] == ACT_MONITOR)
                    rx_response(pid, $urandom_range(0, 8), $urandom_range(0, 5) != 0);
            end else if (sel < 9) begin
                load_slot(4'(si), $urandom_range(0, 4) != 0, 2'($urandom),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63)),
                          4'($urandom));
            end else if (sel < 11) begin
                load_byte(CMD_SLOT_DATA, 4'(si), 3'($urandom), 8'($urandom));
            end else if (sel < 12) begin
                load_byte(CMD_MASTER_BYTE, 4'(si), 3'($urandom), 8'($urandom));
            end else if (sel < 13) begin
                master(CMD_MASTER_FRM, 8'($urandom), 4'($urandom));
            end else if (sel < 14) begin
                master(CMD_MASTER_HDR, pid, 4'd0);
                rx_b(pid, 1'b0);
                rx_response(pid, $urandom_range(0, 8), $urandom_range(0, 3) != 0);
            end else if (sel < 15) begin
                op(($urandom_range(0, 7) == 0) ? CMD_ERASE_ALL : 4'($urandom_range(3, 5)),
                   4'(si));
            end else begin
                send_word(noise_word());
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req = 400;
        for (int i = 0; i < 12; i++) master(CMD_MASTER_FRM, 8'($urandom), 4'd8);
        drain(50);
        for (int i = 0; i < 5; i++) master(CMD_MASTER_HDR, 8'($urandom), 4'd0);
        drain(50);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        drv = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        hold_req = 0;
        hold_cnt = 0;
        stall_mode = 0;
        mode_left = 0;
        burst_left = 0;
        p_tmo = TIMEOUT_RESET;
        for (int i = 0; i < 16; i++) begin
            p_act[i] = '0; p_acn[i] = '0; p_pid[i] = '0; p_len[i] = '0;
        end
        for (int i = 0; i < 128; i++) p_sdata[i] = '0;
        for (int i = 0; i < 9; i++) p_rxbuf[i] = '0;
        for (int i = 0; i < 8; i++) p_mbuf[i] = '0;
        p_cur_pid = '0;
        eng_idle();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_monitor_and_slave();
        set_timeout(8'd1);
        test_master_commands();
        test_table_edits();
        random_traffic(words_sent + 40);
        test_backpressure();
        set_timeout(8'd30);
        random_traffic(words_sent + 20);
        set_timeout(8'($urandom_range(2, 9)));
        random_traffic(words_sent + 35);
        drain(300);

        $display("covered %0d command words and %0d result words", words_sent, results_seen);
        $display("monitor, slave and master frames, timeouts, table edits, back-pressure");
        if (mismatches == 0 && lin_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: lin_slave_monitor_frame_engine.f
src/lsm_pkg.sv
src/lsm_data_ram.sv
src/lin_slave_monitor_frame_engine.sv
bench/tb.sv
